// File: hw/rtl/dpc_pkg.sv
`default_nettype none

package dpc_pkg;

  // Widths of the item fields
  localparam int unsigned CMD_W    = 2;
  localparam int unsigned POS_W    = 31;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned WIN_W    = 31;
  localparam int unsigned RIDX_W   = 10;
  localparam int unsigned CID_W    = 10;
  localparam int unsigned CNT_W    = 11;
  localparam int unsigned DIFF_W   = 33;

  // Command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD = 2'd0,
    CMD_RUN  = 2'd1,
    CMD_READ = 2'd2,
    CMD_NONE = 2'd3
  } cmd_e;

  // One stored point with its windows
  typedef struct packed {
    logic [POS_W-1:0]        first_pos;
    logic signed [VAL_W-1:0] second_val;
    logic [WIN_W-1:0]        first_window;
    logic [WIN_W-1:0]        second_window;
  } point_t;

endpackage

`default_nettype wire

// File: hw/rtl/dpc_ram.sv
`default_nettype none

module dpc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                        wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/density_peak_point_clusterer_core.sv
`default_nettype none
// Density-peak point clusterer.
// Items enter on the input channel (in_valid_i, in_stall_o) and carry a
// command: load a point, run clustering, or read one point's result. Load
// and read items are taken in the idle state; a load gives no result, and a
// read passes S_RD0 and S_RD1, then its result enters the output register.
// A run sweeps the loaded points once to set up the rings, then makes a
// counting pass and a linking pass, each examining the points in each
// point's window, walks each spliced ring member by member, and finally
// filters the points. Each memory read goes through a registered read port.
// Results leave on the output channel (out_valid_o, out_stall_i) through an
// output register, so a waiting result does not stop loads; a finished run or
// read waits while the receiver stalls and its result stays unchanged.
// The min_cluster_size register is written through cfg_valid_i/cfg_ready_o.
// Reset clears the point count, the cluster total and the control state, and
// sets min_cluster_size to one. No clearing pass follows reset.
module density_peak_point_clusterer_core #(
  parameter int unsigned MAX_POINTS = 1024
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_stall_o,
  input  wire logic [dpc_pkg::CMD_W-1:0]          cmd_i,
  input  wire logic [dpc_pkg::POS_W-1:0]          first_pos_i,
  input  wire logic signed [dpc_pkg::VAL_W-1:0]   second_val_i,
  input  wire logic [dpc_pkg::WIN_W-1:0]          first_window_i,
  input  wire logic [dpc_pkg::WIN_W-1:0]          second_window_i,
  input  wire logic [dpc_pkg::RIDX_W-1:0]         read_index_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic      [dpc_pkg::CID_W-1:0]          cluster_id_o,
  output logic                                    kept_o,
  output logic      [dpc_pkg::CNT_W-1:0]          neighbour_count_o,
  output logic      [dpc_pkg::CNT_W-1:0]          cluster_total_o,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [dpc_pkg::CNT_W-1:0]          cfg_data_i
);
  import dpc_pkg::*;

  localparam int unsigned IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CW = $clog2(MAX_POINTS + 1);
  localparam int unsigned MW = (CW > CNT_W) ? CW : CNT_W;
  localparam int unsigned RW = (CW > RIDX_W) ? CW : RIDX_W;
  localparam int unsigned DW = IW + 1;

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_PI, S_PL, S_JR, S_JE, S_IE,
    S_L0, S_L1, S_L2, S_L3, S_F0, S_F1, S_F2,
    S_RD0, S_RD1, S_RUNOUT
  } state_e;

  state_e state_q;

  logic [CW-1:0]     n_q, i_q, j_q, low_q, cnt_q, best_q, ctr_q;
  logic [IW-1:0]     centre_q, k_q, cid_q, cnext_q, lab_q;
  logic              pass2_q, scan_q;
  logic [CNT_W-1:0]  minsz_q;
  logic [RW-1:0]     r_q;
  point_t            pi_q;

  // Memory ports
  logic          pt_we;
  logic [IW-1:0] pt_waddr, pt_raddr;
  point_t        pt_wdata, pt_rdata;
  logic          cnt_we;
  logic [IW-1:0] cnt_waddr, cnt_raddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;
  logic          ring_we;
  logic [IW-1:0] ring_waddr, ring_raddr, ring_wdata, ring_rdata;
  logic          lab_we;
  logic [IW-1:0] lab_waddr, lab_raddr, lab_wdata, lab_rdata;
  logic          kept_we;
  logic [IW-1:0] kept_waddr, kept_raddr;
  logic          kept_wdata, kept_rdata;
  logic          dn_we;
  logic [IW-1:0] dn_waddr, dn_raddr;
  logic [DW-1:0] dn_wdata, dn_rdata;

  logic                in_acc, out_free, i_last, load_ok, res_load;
  logic [DIFF_W-1:0]   d1, a1, d2, a2;
  logic                past, in_f, in_s, better, keep_ok, ring_hit, r_in;
  logic [IW-1:0]       fid;

  assign in_stall_o  = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_o || !out_stall_i;
  assign res_load    = ((state_q == S_RD1) || (state_q == S_RUNOUT)) && out_free;
  assign i_last      = ((i_q + CW'(1)) == n_q);
  assign load_ok     = (n_q != CW'(MAX_POINTS));
  assign r_in        = (r_q < RW'(n_q));

  // Window tests on point i against the point just read
  always_comb begin
    d1 = $signed({2'b00, pi_q.first_pos}) - $signed({2'b00, pt_rdata.first_pos});
    a1 = d1[DIFF_W-1] ? (~d1 + DIFF_W'(1)) : d1;
    d2 = $signed({pi_q.second_val[VAL_W-1], pi_q.second_val})
       - $signed({pt_rdata.second_val[VAL_W-1], pt_rdata.second_val});
    a2 = d2[DIFF_W-1] ? (~d2 + DIFF_W'(1)) : d2;
    past     = !d1[DIFF_W-1] && (d1 > {2'b00, pi_q.first_window});
    in_f     = (a1 <= {2'b00, pi_q.first_window});
    in_s     = (a2 <= {2'b00, pi_q.second_window});
    better   = (cnt_rdata > best_q);
    keep_ok  = (MW'(cnt_rdata) >= MW'(minsz_q));
    ring_hit = (ring_rdata == IW'(i_q));
    fid      = dn_rdata[DW-1] ? dn_rdata[IW-1:0] : IW'(ctr_q);
  end

  // Memory addressing and write selection per state
  always_comb begin
    pt_we      = 1'b0;
    pt_waddr   = IW'(n_q);
    pt_wdata   = '{first_pos: first_pos_i, second_val: second_val_i,
                   first_window: first_window_i, second_window: second_window_i};
    pt_raddr   = IW'(j_q);
    cnt_we     = 1'b0;
    cnt_waddr  = IW'(i_q);
    cnt_wdata  = cnt_q;
    cnt_raddr  = IW'(j_q);
    ring_we    = 1'b0;
    ring_waddr = IW'(i_q);
    ring_wdata = IW'(i_q);
    ring_raddr = k_q;
    lab_we     = 1'b0;
    lab_waddr  = IW'(i_q);
    lab_wdata  = IW'(i_q);
    lab_raddr  = IW'(i_q);
    kept_we    = 1'b0;
    kept_waddr = IW'(i_q);
    kept_wdata = 1'b0;
    kept_raddr = IW'(r_q);
    dn_we      = 1'b0;
    dn_waddr   = IW'(i_q);
    dn_wdata   = '0;
    dn_raddr   = lab_rdata;
    if (in_acc && (cmd_e'(cmd_i) == CMD_LOAD) && load_ok) begin
      pt_we      = 1'b1;
      cnt_we     = 1'b1;
      cnt_waddr  = IW'(n_q);
      cnt_wdata  = '0;
      kept_we    = 1'b1;
      kept_waddr = IW'(n_q);
    end
    case (state_q)
      S_INIT: begin
        ring_we = 1'b1;
        lab_we  = 1'b1;
        kept_we = 1'b1;
        dn_we   = 1'b1;
      end
      S_PI: begin
        pt_raddr = IW'(i_q);
      end
      S_IE: begin
        cnt_we = !pass2_q;
      end
      S_L0: begin
        lab_raddr  = centre_q;
        ring_raddr = centre_q;
      end
      S_L1: begin
        ring_we    = 1'b1;
        ring_waddr = centre_q;
      end
      S_L3: begin
        lab_we    = 1'b1;
        lab_waddr = k_q;
        lab_wdata = cid_q;
        if (ring_hit) begin
          ring_we    = 1'b1;
          ring_waddr = k_q;
          ring_wdata = cnext_q;
        end
      end
      S_F1: begin
        cnt_raddr = lab_rdata;
      end
      S_F2: begin
        if (keep_ok) begin
          lab_we     = 1'b1;
          lab_wdata  = fid;
          kept_we    = 1'b1;
          kept_wdata = 1'b1;
          if (!dn_rdata[DW-1]) begin
            dn_we    = 1'b1;
            dn_waddr = lab_q;
            dn_wdata = {1'b1, IW'(ctr_q)};
          end
        end
      end
      S_RD0, S_RD1: begin
        lab_raddr = IW'(r_q);
        cnt_raddr = IW'(r_q);
      end
      default: begin
      end
    endcase
  end

  // Sequencer, counters and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      n_q         <= '0;
      ctr_q       <= '0;
      minsz_q     <= CNT_W'(1);
      i_q         <= '0;
      j_q         <= '0;
      low_q       <= '0;
      pass2_q     <= 1'b0;
      scan_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        minsz_q <= cfg_data_i;
      end
      if (out_valid_o && !out_stall_i && !res_load) begin
        out_valid_o <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            case (cmd_e'(cmd_i))
              CMD_LOAD: begin
                if (load_ok) begin
                  n_q <= n_q + CW'(1);
                end
              end
              CMD_RUN: begin
                i_q     <= '0;
                pass2_q <= 1'b0;
                low_q   <= '0;
                ctr_q   <= '0;
                state_q <= (n_q == '0) ? S_RUNOUT : S_INIT;
              end
              CMD_READ: begin
                r_q     <= RW'(read_index_i);
                state_q <= S_RD0;
              end
              default: begin
              end
            endcase
          end
        end
        S_INIT: begin
          if (i_last) begin
            i_q     <= '0;
            state_q <= S_PI;
          end else begin
            i_q <= i_q + CW'(1);
          end
        end
        S_PI: begin
          state_q <= S_PL;
        end
        S_PL: begin
          pi_q     <= pt_rdata;
          j_q      <= low_q;
          scan_q   <= 1'b0;
          cnt_q    <= '0;
          best_q   <= '0;
          centre_q <= '0;
          state_q  <= S_JR;
        end
        S_JR: begin
          state_q <= (j_q >= n_q) ? S_IE : S_JE;
        end
        S_JE: begin
          if (!scan_q && past) begin
            j_q     <= j_q + CW'(1);
            low_q   <= j_q + CW'(1);
            state_q <= S_JR;
          end else begin
            scan_q <= 1'b1;
            if (in_f) begin
              if (in_s) begin
                if (!pass2_q) begin
                  cnt_q <= cnt_q + CW'(1);
                end else if (better) begin
                  best_q   <= cnt_rdata;
                  centre_q <= IW'(j_q);
                end
              end
              j_q     <= j_q + CW'(1);
              state_q <= S_JR;
            end else begin
              state_q <= S_IE;
            end
          end
        end
        S_IE: begin
          if (pass2_q && (centre_q != IW'(i_q))) begin
            state_q <= S_L0;
          end else if (!i_last) begin
            i_q     <= i_q + CW'(1);
            state_q <= S_PI;
          end else if (!pass2_q) begin
            i_q     <= '0;
            low_q   <= '0;
            pass2_q <= 1'b1;
            state_q <= S_PI;
          end else begin
            i_q     <= '0;
            state_q <= S_F0;
          end
        end
        S_L0: begin
          state_q <= S_L1;
        end
        S_L1: begin
          cid_q   <= lab_rdata;
          cnext_q <= ring_rdata;
          k_q     <= IW'(i_q);
          state_q <= S_L2;
        end
        S_L2: begin
          state_q <= S_L3;
        end
        S_L3: begin
          if (!ring_hit) begin
            k_q     <= ring_rdata;
            state_q <= S_L2;
          end else if (!i_last) begin
            i_q     <= i_q + CW'(1);
            state_q <= S_PI;
          end else begin
            i_q     <= '0;
            state_q <= S_F0;
          end
        end
        S_F0: begin
          state_q <= S_F1;
        end
        S_F1: begin
          lab_q   <= lab_rdata;
          state_q <= S_F2;
        end
        S_F2: begin
          if (keep_ok && !dn_rdata[DW-1]) begin
            ctr_q <= ctr_q + CW'(1);
          end
          if (i_last) begin
            state_q <= S_RUNOUT;
          end else begin
            i_q     <= i_q + CW'(1);
            state_q <= S_F0;
          end
        end
        S_RD0: begin
          state_q <= S_RD1;
        end
        S_RD1: begin
          if (out_free) begin
            out_valid_o       <= 1'b1;
            cluster_id_o      <= (r_in && kept_rdata) ? CID_W'(lab_rdata) : '0;
            kept_o            <= r_in && kept_rdata;
            neighbour_count_o <= r_in ? CNT_W'(cnt_rdata) : '0;
            cluster_total_o   <= CNT_W'(ctr_q);
            state_q           <= S_IDLE;
          end
        end
        S_RUNOUT: begin
          if (out_free) begin
            out_valid_o       <= 1'b1;
            cluster_id_o      <= '0;
            kept_o            <= 1'b0;
            neighbour_count_o <= '0;
            cluster_total_o   <= CNT_W'(ctr_q);
            state_q           <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Point coordinates and windows
  dpc_ram #(.Width($bits(point_t)), .Depth(MAX_POINTS)) u_pt_ram (
    .clk_i, .we_i(pt_we), .waddr_i(pt_waddr), .wdata_i(pt_wdata),
    .raddr_i(pt_raddr), .rdata_o(pt_rdata)
  );

  // Neighbour counts
  dpc_ram #(.Width(CW), .Depth(MAX_POINTS)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  // Ring successors
  dpc_ram #(.Width(IW), .Depth(MAX_POINTS)) u_ring_ram (
    .clk_i, .we_i(ring_we), .waddr_i(ring_waddr), .wdata_i(ring_wdata),
    .raddr_i(ring_raddr), .rdata_o(ring_rdata)
  );

  // Labels, later dense ids
  dpc_ram #(.Width(IW), .Depth(MAX_POINTS)) u_lab_ram (
    .clk_i, .we_i(lab_we), .waddr_i(lab_waddr), .wdata_i(lab_wdata),
    .raddr_i(lab_raddr), .rdata_o(lab_rdata)
  );

  // Keep flags
  dpc_ram #(.Width(1), .Depth(MAX_POINTS)) u_kept_ram (
    .clk_i, .we_i(kept_we), .waddr_i(kept_waddr), .wdata_i(kept_wdata),
    .raddr_i(kept_raddr), .rdata_o(kept_rdata)
  );

  // Dense id map with assigned flag on top
  dpc_ram #(.Width(DW), .Depth(MAX_POINTS)) u_dn_ram (
    .clk_i, .we_i(dn_we), .waddr_i(dn_waddr), .wdata_i(dn_wdata),
    .raddr_i(dn_raddr), .rdata_o(dn_rdata)
  );

endmodule

`default_nettype wire

// File: hw/rtl/dpc_checker.sv
`default_nettype none

module dpc_checker (
  input wire logic                               clk_i,
  input wire logic                               rst_ni,
  input wire logic                               in_valid_i,
  input wire logic                               in_stall_o,
  input wire logic [dpc_pkg::CMD_W-1:0]          cmd_i,
  input wire logic                               out_valid_o,
  input wire logic                               out_stall_i,
  input wire logic [dpc_pkg::CID_W-1:0]          cluster_id_o,
  input wire logic                               kept_o,
  input wire logic [dpc_pkg::CNT_W-1:0]          neighbour_count_o,
  input wire logic [dpc_pkg::CNT_W-1:0]          cluster_total_o
);
  import dpc_pkg::*;

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cluster_id_o) &&
    $stable(kept_o) && $stable(neighbour_count_o) && $stable(cluster_total_o))
    else $error("result changed while stalled");

  // A point that is not kept carries no cluster id.
  a_drop_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !kept_o |-> cluster_id_o == '0)
    else $error("dropped point with nonzero id");

  // A kept point's id lies below the cluster total.
  a_id_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kept_o |-> CNT_W'(cluster_id_o) < cluster_total_o)
    else $error("cluster id beyond total");

  // A run transfer keeps the input closed in the next cycle.
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_e'(cmd_i) == CMD_RUN) |=> in_stall_o)
    else $error("input open right after run");

endmodule

bind density_peak_point_clusterer_core dpc_checker u_dpc_checker (.*);

`default_nettype wire
